[hw/rtl/cacfar_pkg.sv]
`default_nettype none
package cacfar_pkg;

	localparam int MAX_TRAIN   = 16;
	localparam int MAX_GUARD   = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int LINE_DEPTH  = 2 * (MAX_TRAIN + MAX_GUARD) + 1;
	localparam int PTR_W       = $clog2(LINE_DEPTH);
	localparam int TRN_W       = $clog2(MAX_TRAIN + 1);
	localparam int GRD_W       = $clog2(MAX_GUARD + 1);
	localparam int WIN_W       = $clog2(MAX_TRAIN + MAX_GUARD + 1);
	localparam int CNT_W       = 17;
	localparam int IDX_W       = 16;
	localparam int SUM_W       = SAMPLE_BITS + TRN_W + 1;
	localparam int SF_W        = 16;
	localparam int PROD_W      = SF_W + SUM_W;
	localparam int QUO_W       = PROD_W - 1;
	localparam int VT_W        = SAMPLE_BITS + TRN_W;
	localparam int THR_W       = 32;
	localparam int THR_SHIFT   = 9;
	localparam int DIV_CNT_W   = $clog2(QUO_W);
	localparam int TC_W        = 5;
	localparam int GC_W        = 4;
	localparam int CFG_W       = 16;
	localparam int CIDX_W      = 2;
	localparam int FIFO_DEPTH  = 4;

	typedef enum logic [CIDX_W-1:0] {
		REG_TRAIN,
		REG_GUARD,
		REG_SCALE
	} cfg_reg_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_VAL,
		B_SUM,
		B_MUL,
		B_DIV,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic [TRN_W-1:0] train;
		logic [GRD_W-1:0] guard;
		logic [WIN_W-1:0] win;
		logic [SF_W-1:0]  scale;
	} eff_cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] idx;
		logic [PTR_W-1:0] ptr;
		logic             full;
		logic             run_end;
		logic             frame_end;
	} cell_task_t;

	typedef struct packed {
		logic                   en;
		logic [PTR_W-1:0]       addr;
		logic [SAMPLE_BITS-1:0] data;
	} mem_wr_t;

	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
		input logic [PTR_W-1:0] b);
		logic [PTR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (PTR_W+1)'(LINE_DEPTH)) begin
			s = s - (PTR_W+1)'(LINE_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage
`default_nettype wire

[hw/rtl/cacfar_fifo.sv]
`default_nettype none
module cacfar_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire cacfar_pkg::cell_task_t push_data,
	input  wire logic                   pop,
	output cacfar_pkg::cell_task_t      head,
	output logic                        full,
	output logic                        empty
);
	import cacfar_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	cell_task_t       entry_q [FIFO_DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;

	assign head  = entry_q[rd_q];
	assign full  = (cnt_q == (AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

[hw/rtl/cacfar_front.sv]
`default_nettype none
module cacfar_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [cacfar_pkg::SAMPLE_BITS-1:0]  sample_magnitude,
	input  wire logic                                frame_last,
	input  wire cacfar_pkg::eff_cfg_t                cfg,
	input  wire logic                                back_idle,
	input  wire logic                                fifo_full,
	input  wire logic                                fifo_empty,
	output logic                                     push,
	output cacfar_pkg::cell_task_t                   push_data,
	output cacfar_pkg::mem_wr_t                      mem_wr
);
	import cacfar_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] cr_q;
	logic [PTR_W-1:0] cr_ptr_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] end_q;
	logic             last_q;
	logic             gen_q;
	logic             acc;
	logic             due;
	logic [CNT_W-1:0] win_ext;
	logic [CNT_W-1:0] end_d;

	always_comb begin
		win_ext  = CNT_W'(cfg.win);
		in_ready = !gen_q && fifo_empty && back_idle;
		acc      = in_valid && in_ready;
		due      = frame_last || ((cnt_q >= win_ext) && (cr_q <= cnt_q - win_ext));
		end_d    = frame_last ? cnt_q : cnt_q - win_ext;

		mem_wr.en   = acc;
		mem_wr.addr = wr_ptr_q;
		mem_wr.data = sample_magnitude;

		push                = gen_q && !fifo_full;
		push_data.idx       = cr_q;
		push_data.ptr       = cr_ptr_q;
		push_data.full      = (cr_q >= win_ext) &&
			(({1'b0, cr_q} + {1'b0, win_ext}) <= {1'b0, k_q});
		push_data.run_end   = (cr_q == end_q);
		push_data.frame_end = last_q && (cr_q == k_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			cr_q     <= '0;
			cr_ptr_q <= '0;
			k_q      <= '0;
			end_q    <= '0;
			last_q   <= 1'b0;
			gen_q    <= 1'b0;
		end else begin
			if (acc) begin
				if (frame_last) begin
					cnt_q    <= '0;
					wr_ptr_q <= '0;
				end else begin
					cnt_q    <= cnt_q + CNT_W'(1);
					wr_ptr_q <= wrap_add(wr_ptr_q, PTR_W'(1));
				end
				k_q    <= cnt_q;
				last_q <= frame_last;
				end_q  <= end_d;
				gen_q  <= due;
			end
			if (push) begin
				cr_q     <= cr_q + CNT_W'(1);
				cr_ptr_q <= wrap_add(cr_ptr_q, PTR_W'(1));
				if (cr_q == end_q) begin
					gen_q <= 1'b0;
					if (last_q) begin
						cr_q     <= '0;
						cr_ptr_q <= '0;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

[hw/rtl/cacfar_back.sv]
`default_nettype none
module cacfar_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire cacfar_pkg::eff_cfg_t                cfg,
	input  wire cacfar_pkg::mem_wr_t                 mem_wr,
	input  wire cacfar_pkg::cell_task_t              head,
	input  wire logic                                fifo_empty,
	output logic                                     pop,
	output logic                                     back_idle,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [cacfar_pkg::IDX_W-1:0]             cell_index,
	output logic [cacfar_pkg::SAMPLE_BITS-1:0]       cell_value,
	output logic [cacfar_pkg::THR_W-1:0]             noise_threshold,
	output logic                                     target_found,
	output logic                                     full_window,
	output logic                                     run_end,
	output logic                                     frame_end
);
	import cacfar_pkg::*;

	logic [SAMPLE_BITS-1:0] line_mem [LINE_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_a_q;
	logic [SAMPLE_BITS-1:0] rd_b_q;
	logic [PTR_W-1:0]       addr_a;

	back_state_t            state_q;
	back_state_t            state_d;
	cell_task_t             task_q;
	logic [SAMPLE_BITS-1:0] v_q;
	logic [SUM_W-1:0]       sum_q;
	logic [TRN_W-1:0]       cnt_q;
	logic [PTR_W-1:0]       lptr_q;
	logic [PTR_W-1:0]       rptr_q;
	logic [PROD_W-1:0]      prod_q;
	logic [PROD_W-1:0]      prod_d;
	logic [VT_W-1:0]        vt_q;
	logic [QUO_W-1:0]       quo_q;
	logic [TRN_W-1:0]       rem_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic [TRN_W:0]         trial;
	logic                   ge;
	logic                   load_out;
	logic [THR_W-1:0]       thr_sat;
	logic                   hit;

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			line_mem[mem_wr.addr] <= mem_wr.data;
		end
		rd_a_q <= line_mem[addr_a];
		rd_b_q <= line_mem[rptr_q];
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		addr_a   = lptr_q;
		load_out = 1'b0;
		case (state_q)
			B_IDLE: begin
				addr_a = head.ptr;
				if (!fifo_empty) begin
					pop     = 1'b1;
					state_d = B_VAL;
				end
			end
			B_VAL: begin
				state_d = task_q.full ? B_SUM : B_OUT;
			end
			B_SUM: begin
				if (cnt_q == cfg.train) begin
					state_d = B_MUL;
				end
			end
			B_MUL: begin
				state_d = B_DIV;
			end
			B_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (!out_valid || out_ready) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_comb begin
		back_idle = (state_q == B_IDLE);
		prod_d    = PROD_W'(cfg.scale) * PROD_W'(sum_q);
		trial     = {rem_q, quo_q[QUO_W-1]};
		ge        = (trial >= {1'b0, cfg.train});
		thr_sat   = (|quo_q[QUO_W-1:THR_W]) ? '1 : quo_q[THR_W-1:0];
		hit       = (PROD_W'({vt_q, THR_SHIFT'(0)}) > prod_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop) begin
					task_q <= head;
				end
			end
			B_VAL: begin
				v_q    <= rd_a_q;
				sum_q  <= '0;
				cnt_q  <= '0;
				lptr_q <= wrap_add(task_q.ptr, PTR_W'(LINE_DEPTH) - PTR_W'(cfg.win));
				rptr_q <= wrap_add(task_q.ptr, PTR_W'(cfg.guard) + PTR_W'(1));
			end
			B_SUM: begin
				cnt_q  <= cnt_q + TRN_W'(1);
				lptr_q <= wrap_add(lptr_q, PTR_W'(1));
				rptr_q <= wrap_add(rptr_q, PTR_W'(1));
				if (cnt_q != '0) begin
					sum_q <= sum_q + SUM_W'(rd_a_q) + SUM_W'(rd_b_q);
				end
			end
			B_MUL: begin
				prod_q    <= prod_d;
				quo_q     <= prod_d[PROD_W-1:1];
				vt_q      <= VT_W'(v_q) * VT_W'(cfg.train);
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			B_DIV: begin
				quo_q     <= {quo_q[QUO_W-2:0], ge};
				rem_q     <= ge ? TRN_W'(trial - {1'b0, cfg.train}) : TRN_W'(trial);
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			B_OUT: begin
				if (load_out) begin
					cell_index      <= task_q.idx[IDX_W-1:0];
					cell_value      <= v_q;
					noise_threshold <= task_q.full ? thr_sat : '0;
					target_found    <= task_q.full && hit;
					full_window     <= task_q.full;
					run_end         <= task_q.run_end;
					frame_end       <= task_q.frame_end;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

[hw/rtl/cell_averaging_cfar_detector_top.sv]
`default_nettype none
// Channel  Handshake             Payload
// in       in_valid/in_ready     sample_magnitude, frame_last
// out      out_valid/out_ready   cell_index, cell_value, noise_threshold, target_found,
//                                full_window, run_end, frame_end
// cfg      cfg_wr_en             cfg_index, cfg_wr_data
//
// A border cell passes through the idle, value and output states; a full-window cell
// adds the two-port summing pass over the sample line, the multiply and the bit-serial
// divider. An item is accepted only after every result of the previous item has been
// computed, and a computed result waits in the output register while the next item is
// taken in.
// Reset clears all control state and loads the register defaults; the sample line is
// not cleared.
module cell_averaging_cfar_detector_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [cacfar_pkg::SAMPLE_BITS-1:0]  sample_magnitude,
	input  wire logic                                frame_last,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [cacfar_pkg::IDX_W-1:0]             cell_index,
	output logic [cacfar_pkg::SAMPLE_BITS-1:0]       cell_value,
	output logic [cacfar_pkg::THR_W-1:0]             noise_threshold,
	output logic                                     target_found,
	output logic                                     full_window,
	output logic                                     run_end,
	output logic                                     frame_end,
	input  wire logic                                cfg_wr_en,
	input  wire logic [cacfar_pkg::CIDX_W-1:0]       cfg_index,
	input  wire logic [cacfar_pkg::CFG_W-1:0]        cfg_wr_data
);
	import cacfar_pkg::*;

	logic [TC_W-1:0] train_q;
	logic [GC_W-1:0] guard_q;
	logic [SF_W-1:0] scale_q;
	eff_cfg_t        cfg;
	logic            back_idle;
	logic            fifo_full;
	logic            fifo_empty;
	logic            push;
	logic            pop;
	cell_task_t      push_data;
	cell_task_t      head;
	mem_wr_t         mem_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			train_q <= TC_W'(10);
			guard_q <= GC_W'(2);
			scale_q <= SF_W'(1280);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_TRAIN: train_q <= cfg_wr_data[TC_W-1:0];
				REG_GUARD: guard_q <= cfg_wr_data[GC_W-1:0];
				REG_SCALE: scale_q <= cfg_wr_data[SF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (train_q == '0) begin
			cfg.train = TRN_W'(1);
		end else if (train_q > TC_W'(MAX_TRAIN)) begin
			cfg.train = TRN_W'(MAX_TRAIN);
		end else begin
			cfg.train = TRN_W'(train_q);
		end
		cfg.guard = (guard_q > GC_W'(MAX_GUARD)) ? GRD_W'(MAX_GUARD) : GRD_W'(guard_q);
		cfg.win   = WIN_W'(cfg.train) + WIN_W'(cfg.guard);
		cfg.scale = scale_q;
	end

	cacfar_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sample_magnitude (sample_magnitude),
		.frame_last       (frame_last),
		.cfg              (cfg),
		.back_idle        (back_idle),
		.fifo_full        (fifo_full),
		.fifo_empty       (fifo_empty),
		.push             (push),
		.push_data        (push_data),
		.mem_wr           (mem_wr)
	);

	cacfar_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	cacfar_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.mem_wr          (mem_wr),
		.head            (head),
		.fifo_empty      (fifo_empty),
		.pop             (pop),
		.back_idle       (back_idle),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cell_index      (cell_index),
		.cell_value      (cell_value),
		.noise_threshold (noise_threshold),
		.target_found    (target_found),
		.full_window     (full_window),
		.run_end         (run_end),
		.frame_end       (frame_end)
	);

	a_ready_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (fifo_empty && back_idle))
		else $error("input taken while cells are still pending");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full)
		else $error("cell queue written while full");

	a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> run_end)
		else $error("frame end reported on a result that does not close its item");

	a_border_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !full_window) |-> (!target_found && (noise_threshold == '0)))
		else $error("border cell reported with a threshold or a target");
endmodule
`default_nettype wire
